@@ src/rva_pkg.sv @@
// rva_pkg: shared constants, types and functions for the rotate view about axis block
// cordic arctangent table, fixed point constants and the front-to-back item record
// no dependencies
`default_nettype none
package rva_pkg;

   localparam int unsigned COORD_FRAC_BITS_DEF = 16;
   localparam int unsigned AXIS_FRAC_BITS_DEF  = 14;
   localparam int unsigned ANGLE_FRAC_BITS_DEF = 13;
   localparam int unsigned CORDIC_STEPS_DEF    = 16;

   localparam int unsigned QF        = 30;
   localparam int unsigned ATAN_COUNT = 24;
   localparam int unsigned AW        = 40;

   localparam logic signed [AW-1:0] ONE_Q     = 40'sd1073741824;
   localparam logic signed [AW-1:0] PI_Q      = 40'sd3373259426;
   localparam logic signed [AW-1:0] HALF_PI_Q = 40'sd1686629713;
   localparam logic signed [AW-1:0] TWO_PI_Q  = 40'sd6746518852;
   localparam logic signed [AW-1:0] GAIN_Q    = 40'sd652032874;
   localparam logic signed [AW-1:0] ENT_LIM   = 40'sd4294967296;

   function automatic logic signed [AW-1:0] atan_q(input int unsigned i);
      logic signed [AW-1:0] v;
      unique case (i)
         0:  v = 40'sd843314857;
         1:  v = 40'sd497837829;
         2:  v = 40'sd263043836;
         3:  v = 40'sd133525158;
         4:  v = 40'sd67021686;
         5:  v = 40'sd33543515;
         6:  v = 40'sd16775850;
         7:  v = 40'sd8388437;
         8:  v = 40'sd4194282;
         9:  v = 40'sd2097149;
         10: v = 40'sd1048575;
         11: v = 40'sd524287;
         12: v = 40'sd262143;
         13: v = 40'sd131071;
         14: v = 40'sd65535;
         15: v = 40'sd32767;
         16: v = 40'sd16383;
         17: v = 40'sd8191;
         18: v = 40'sd4095;
         19: v = 40'sd2047;
         20: v = 40'sd1023;
         21: v = 40'sd511;
         22: v = 40'sd255;
         23: v = 40'sd127;
         default: v = '0;
      endcase
      return v;
   endfunction

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [32:0] d_x;
      logic signed [32:0] d_y;
      logic signed [32:0] d_z;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic signed [AW-1:0] ang;
      logic neg;
   } front_item_type;

endpackage
`default_nettype wire

@@ src/rva_ram.sv @@
// rva_ram: generic single write port, single registered read port ram
// no dependencies
`default_nettype none
module rva_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ src/rva_front.sv @@
// rva_front: accepts items, forms the view direction and reduces the angle
// depends on rva_pkg
`default_nettype none
module rva_front #(
   parameter int unsigned ANGLE_FRAC_BITS = rva_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic signed [31:0] pos_x,
   input  wire logic signed [31:0] pos_y,
   input  wire logic signed [31:0] pos_z,
   input  wire logic signed [31:0] view_x,
   input  wire logic signed [31:0] view_y,
   input  wire logic signed [31:0] view_z,
   input  wire logic signed [15:0] axis_x,
   input  wire logic signed [15:0] axis_y,
   input  wire logic signed [15:0] axis_z,
   input  wire logic signed [15:0] turn_angle,
   output      logic               out_valid,
   output      rva_pkg::front_item_type out_item
);
   localparam int unsigned AW = rva_pkg::AW;

   logic valid1_ff;
   rva_pkg::front_item_type s1_ff, s1_in, s2_ff, s2_in;
   logic valid2_ff;
   logic signed [AW-1:0] a0, a1;

   // first stage: differences and angle widening with one subtract or add
   always_comb begin
      a0 = AW'(turn_angle) <<< (rva_pkg::QF - ANGLE_FRAC_BITS);
      s1_in        = '0;
      s1_in.pos_x  = pos_x;
      s1_in.pos_y  = pos_y;
      s1_in.pos_z  = pos_z;
      s1_in.d_x    = 33'(view_x) - 33'(pos_x);
      s1_in.d_y    = 33'(view_y) - 33'(pos_y);
      s1_in.d_z    = 33'(view_z) - 33'(pos_z);
      s1_in.axis_x = axis_x;
      s1_in.axis_y = axis_y;
      s1_in.axis_z = axis_z;
      // magnitude of the widened angle stays within 4 rad (below 3*pi), one wrap is enough
      if (a0 > rva_pkg::PI_Q) begin
         a1 = a0 - rva_pkg::TWO_PI_Q;
      end else if (a0 < -rva_pkg::PI_Q) begin
         a1 = a0 + rva_pkg::TWO_PI_Q;
      end else begin
         a1 = a0;
      end
      s1_in.ang = a1;
   end

   // second stage: fold into half circle
   always_comb begin
      s2_in = s1_ff;
      s2_in.neg = 1'b0;
      if (s1_ff.ang > rva_pkg::HALF_PI_Q) begin
         s2_in.ang = s1_ff.ang - rva_pkg::PI_Q;
         s2_in.neg = 1'b1;
      end else if (s1_ff.ang < -rva_pkg::HALF_PI_Q) begin
         s2_in.ang = s1_ff.ang + rva_pkg::PI_Q;
         s2_in.neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   assign out_valid = valid2_ff;
   assign out_item  = s2_ff;
endmodule
`default_nettype wire

@@ src/rva_back.sv @@
// rva_back: cordic pipeline, matrix entries and rotated target with saturation
// depends on rva_pkg
`default_nettype none
module rva_back #(
   parameter int unsigned AXIS_FRAC_BITS = rva_pkg::AXIS_FRAC_BITS_DEF,
   parameter int unsigned CORDIC_STEPS   = rva_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire rva_pkg::front_item_type in_item,
   output      logic               out_valid,
   output      logic signed [31:0] out_x,
   output      logic signed [31:0] out_y,
   output      logic signed [31:0] out_z
);
   localparam int unsigned AW = rva_pkg::AW;
   localparam int unsigned NS = (CORDIC_STEPS < rva_pkg::ATAN_COUNT) ?
                                CORDIC_STEPS : rva_pkg::ATAN_COUNT;
   localparam int unsigned NP = NS + 6;
   localparam int unsigned SH = 2 * AXIS_FRAC_BITS;

   logic                    vld_ff [NP+1];
   rva_pkg::front_item_type it_ff  [NS+1];
   logic signed [AW-1:0]    cx_ff  [NS+1];
   logic signed [AW-1:0]    cy_ff  [NS+1];
   logic signed [AW-1:0]    cz_ff  [NS+1];

   always_comb begin
      vld_ff[0] = in_valid;
      it_ff[0]  = in_item;
      cx_ff[0]  = rva_pkg::GAIN_Q;
      cy_ff[0]  = '0;
      cz_ff[0]  = in_item.ang;
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= NP; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   for (genvar g = 0; g < NS; g++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (advance) begin
            it_ff[g+1] <= it_ff[g];
            if (!cz_ff[g][AW-1]) begin
               cx_ff[g+1] <= cx_ff[g] - (cy_ff[g] >>> g);
               cy_ff[g+1] <= cy_ff[g] + (cx_ff[g] >>> g);
               cz_ff[g+1] <= cz_ff[g] - rva_pkg::atan_q(g);
            end else begin
               cx_ff[g+1] <= cx_ff[g] + (cy_ff[g] >>> g);
               cy_ff[g+1] <= cy_ff[g] - (cx_ff[g] >>> g);
               cz_ff[g+1] <= cz_ff[g] + rva_pkg::atan_q(g);
            end
         end
      end
   end

   // stage a: c, s, t and axis products
   rva_pkg::front_item_type ia_ff;
   logic signed [AW-1:0] c_ff, s_ff, t_ff;
   logic signed [31:0] pxx_ff, pyy_ff, pzz_ff, pxy_ff, pxz_ff, pyz_ff;
   logic signed [AW-1:0] c_in, s_in;
   always_comb begin
      c_in = it_ff[NS].neg ? -cx_ff[NS] : cx_ff[NS];
      s_in = it_ff[NS].neg ? -cy_ff[NS] : cy_ff[NS];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         ia_ff  <= it_ff[NS];
         c_ff   <= c_in;
         s_ff   <= s_in;
         t_ff   <= rva_pkg::ONE_Q - c_in;
         pxx_ff <= 32'(it_ff[NS].axis_x) * 32'(it_ff[NS].axis_x);
         pyy_ff <= 32'(it_ff[NS].axis_y) * 32'(it_ff[NS].axis_y);
         pzz_ff <= 32'(it_ff[NS].axis_z) * 32'(it_ff[NS].axis_z);
         pxy_ff <= 32'(it_ff[NS].axis_x) * 32'(it_ff[NS].axis_y);
         pxz_ff <= 32'(it_ff[NS].axis_x) * 32'(it_ff[NS].axis_z);
         pyz_ff <= 32'(it_ff[NS].axis_y) * 32'(it_ff[NS].axis_z);
      end
   end

   // stage b: t parts and s parts
   rva_pkg::front_item_type ib_ff;
   logic signed [AW-1:0] c2_ff;
   logic signed [AW-1:0] txx_ff, tyy_ff, tzz_ff, txy_ff, txz_ff, tyz_ff;
   logic signed [AW-1:0] sx_ff, sy_ff, sz_ff;
   function automatic logic signed [AW-1:0] tp(input logic signed [AW-1:0] t,
                                              input logic signed [31:0] p);
      logic signed [71:0] w;
      w = 72'(t) * 72'(p);
      return AW'(w >>> SH);
   endfunction
   function automatic logic signed [AW-1:0] sp(input logic signed [AW-1:0] s,
                                              input logic signed [15:0] a);
      logic signed [55:0] w;
      w = 56'(s) * 56'(a);
      return AW'(w >>> AXIS_FRAC_BITS);
   endfunction
   always_ff @(posedge clock) begin
      if (advance) begin
         ib_ff  <= ia_ff;
         c2_ff  <= c_ff;
         txx_ff <= tp(t_ff, pxx_ff);
         tyy_ff <= tp(t_ff, pyy_ff);
         tzz_ff <= tp(t_ff, pzz_ff);
         txy_ff <= tp(t_ff, pxy_ff);
         txz_ff <= tp(t_ff, pxz_ff);
         tyz_ff <= tp(t_ff, pyz_ff);
         sx_ff  <= sp(s_ff, ia_ff.axis_x);
         sy_ff  <= sp(s_ff, ia_ff.axis_y);
         sz_ff  <= sp(s_ff, ia_ff.axis_z);
      end
   end

   // stage c: entries with clamp
   function automatic logic signed [33:0] clampe(input logic signed [AW-1:0] v);
      if (v > rva_pkg::ENT_LIM) begin
         return 34'(rva_pkg::ENT_LIM);
      end else if (v < -rva_pkg::ENT_LIM) begin
         return 34'(-rva_pkg::ENT_LIM);
      end
      return 34'(v);
   endfunction
   rva_pkg::front_item_type ic_ff;
   logic signed [33:0] m_ff [9];
   always_ff @(posedge clock) begin
      if (advance) begin
         ic_ff   <= ib_ff;
         m_ff[0] <= clampe(c2_ff + txx_ff);
         m_ff[1] <= clampe(txy_ff - sz_ff);
         m_ff[2] <= clampe(txz_ff + sy_ff);
         m_ff[3] <= clampe(txy_ff + sz_ff);
         m_ff[4] <= clampe(c2_ff + tyy_ff);
         m_ff[5] <= clampe(tyz_ff - sx_ff);
         m_ff[6] <= clampe(txz_ff - sy_ff);
         m_ff[7] <= clampe(tyz_ff + sx_ff);
         m_ff[8] <= clampe(c2_ff + tzz_ff);
      end
   end

   // stage d: partial products, direction split into high and low halves
   rva_pkg::front_item_type id_ff;
   logic signed [50:0] ph_ff [9];
   logic signed [51:0] pl_ff [9];
   logic signed [16:0] dh [3];
   logic signed [16:0] dl [3];
   always_comb begin
      dh[0] = 17'(ic_ff.d_x >>> 16);
      dh[1] = 17'(ic_ff.d_y >>> 16);
      dh[2] = 17'(ic_ff.d_z >>> 16);
      dl[0] = {1'b0, ic_ff.d_x[15:0]};
      dl[1] = {1'b0, ic_ff.d_y[15:0]};
      dl[2] = {1'b0, ic_ff.d_z[15:0]};
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         id_ff <= ic_ff;
         for (int i = 0; i < 9; i++) begin
            ph_ff[i] <= 51'(m_ff[i]) * 51'(dh[i%3]);
            pl_ff[i] <= 52'(m_ff[i]) * 52'(dl[i%3]);
         end
      end
   end

   // stage e: row sums
   rva_pkg::front_item_type ie_ff;
   logic signed [52:0] hi_ff [3];
   logic signed [53:0] lo_ff [3];
   always_ff @(posedge clock) begin
      if (advance) begin
         ie_ff <= id_ff;
         for (int r = 0; r < 3; r++) begin
            hi_ff[r] <= 53'(ph_ff[3*r]) + 53'(ph_ff[3*r+1]) + 53'(ph_ff[3*r+2]);
            lo_ff[r] <= 54'(pl_ff[3*r]) + 54'(pl_ff[3*r+1]) + 54'(pl_ff[3*r+2])
                        + 54'sd536870912;
         end
      end
   end

   // stage f: combine, add position and saturate
   logic signed [31:0] o_ff [3];
   logic signed [70:0] tot [3];
   logic signed [40:0] rot [3];
   logic signed [41:0] sum [3];
   logic signed [31:0] pp  [3];
   always_comb begin
      pp[0] = ie_ff.pos_x;
      pp[1] = ie_ff.pos_y;
      pp[2] = ie_ff.pos_z;
      for (int r = 0; r < 3; r++) begin
         tot[r] = (71'(hi_ff[r]) <<< 16) + 71'(lo_ff[r]);
         rot[r] = 41'(tot[r] >>> rva_pkg::QF);
         sum[r] = 42'(pp[r]) + 42'(rot[r]);
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            if (sum[r] > 42'sd2147483647) begin
               o_ff[r] <= 32'sh7fffffff;
            end else if (sum[r] < -42'sd2147483648) begin
               o_ff[r] <= 32'sh80000000;
            end else begin
               o_ff[r] <= 32'(sum[r]);
            end
         end
      end
   end

   assign out_valid = vld_ff[NP];
   assign out_x = o_ff[0];
   assign out_y = o_ff[1];
   assign out_z = o_ff[2];
endmodule
`default_nettype wire

@@ src/rotate_view_about_axis_top.sv @@
// rotate_view_about_axis_top: front stage, item queue, rotation back end and result queue
// depends on rva_pkg, rva_front, rva_ram, rva_back
//
// channel   ports                      accept
// input     req_*  push, full          push && !full
// result    rsp_*  empty, pop          pop && !empty
//
// one item per cycle sustained while results are popped and the back does not stall; a result
// reaches the ports after its item passes the front stages, the item queue, the cordic and
// matrix stages of the back end, and the result queue ram and output register
// synchronous reset empties both queues and clears all valid flags
// the back pipeline stalls as a whole only when the result queue could not
// take what is in flight; the front stalls through full when its queue fills
`default_nettype none
module rotate_view_about_axis_top #(
   parameter int unsigned COORD_FRAC_BITS = rva_pkg::COORD_FRAC_BITS_DEF,
   parameter int unsigned AXIS_FRAC_BITS  = rva_pkg::AXIS_FRAC_BITS_DEF,
   parameter int unsigned ANGLE_FRAC_BITS = rva_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int unsigned CORDIC_STEPS    = rva_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output      logic               full,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic signed [31:0] req_view_x,
   input  wire logic signed [31:0] req_view_y,
   input  wire logic signed [31:0] req_view_z,
   input  wire logic signed [15:0] req_axis_x,
   input  wire logic signed [15:0] req_axis_y,
   input  wire logic signed [15:0] req_axis_z,
   input  wire logic signed [15:0] req_turn_angle,
   output      logic               empty,
   input  wire logic               pop,
   output      logic signed [31:0] rsp_new_view_x,
   output      logic signed [31:0] rsp_new_view_y,
   output      logic signed [31:0] rsp_new_view_z
);
   localparam int unsigned NS = (CORDIC_STEPS < rva_pkg::ATAN_COUNT) ?
                                CORDIC_STEPS : rva_pkg::ATAN_COUNT;
   localparam int unsigned LAT = NS + 6;
   // result queue holds everything in flight plus skid
   localparam int unsigned RD = 1 << $clog2(LAT + 4);
   localparam int unsigned RW = $clog2(RD);
   localparam int unsigned QD = 4;
   localparam int unsigned QW = $clog2(QD);
   localparam int unsigned IW = $bits(rva_pkg::front_item_type);

   logic                    acc;
   logic                    f_valid;
   rva_pkg::front_item_type f_item;
   logic [QW:0]             qcnt_ff, qcnt_in;
   logic [QW-1:0]           qwp_ff, qrp_ff;
   logic [QW:0]             fin_ff, fin_in;
   rva_pkg::front_item_type qmem_ff [QD];
   logic                    take;
   logic                    advance;
   logic                    b_valid;
   logic signed [31:0]      bx, by, bz;
   logic [RW:0]             rcnt_ff, rcnt_in, rinfl_ff, rinfl_in;
   logic [RW-1:0]           rwp_ff, rrp_ff;
   logic [95:0]             rd_data;
   logic                    rvalid_ff;
   logic                    rrd;
   logic [RW-1:0]           rrd_addr;
   logic                    rsk_ff;
   logic                    skv_ff;
   logic [95:0]             sk_ff;
   logic [1:0]              occ;

   // front accepts while its items in flight plus queue stay within the queue
   assign full = (32'(qcnt_ff) + 32'(fin_ff)) >= QD;
   assign acc  = push && !full;

   rva_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .in_valid(acc),
      .pos_x(req_pos_x), .pos_y(req_pos_y), .pos_z(req_pos_z),
      .view_x(req_view_x), .view_y(req_view_y), .view_z(req_view_z),
      .axis_x(req_axis_x), .axis_y(req_axis_y), .axis_z(req_axis_z),
      .turn_angle(req_turn_angle), .out_valid(f_valid), .out_item(f_item)
   );

   // back advances when the result queue has room for all in flight
   assign advance = (32'(rcnt_ff) + 32'(rinfl_ff)) < (RD - 1);
   assign take    = advance && (qcnt_ff != '0);

   always_comb begin
      fin_in  = fin_ff + (acc ? 1'b1 : 1'b0) - (f_valid ? 1'b1 : 1'b0);
      qcnt_in = qcnt_ff + (f_valid ? 1'b1 : 1'b0) - (take ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qcnt_ff <= '0;
         fin_ff  <= '0;
         qwp_ff  <= '0;
         qrp_ff  <= '0;
      end else begin
         qcnt_ff <= qcnt_in;
         fin_ff  <= fin_in;
         if (f_valid) begin
            qwp_ff <= qwp_ff + 1'b1;
         end
         if (take) begin
            qrp_ff <= qrp_ff + 1'b1;
         end
      end
      if (f_valid) begin
         qmem_ff[qwp_ff] <= f_item;
      end
   end

   rva_back #(.AXIS_FRAC_BITS(AXIS_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(take),
      .in_item(qmem_ff[qrp_ff]), .out_valid(b_valid),
      .out_x(bx), .out_y(by), .out_z(bz)
   );

   // result queue: ram plus output register and one skid register
   logic b_wr;
   logic out_take;
   assign b_wr     = advance && b_valid;
   assign out_take = pop && !empty;
   assign occ      = 2'(rvalid_ff) + 2'(skv_ff) + 2'(rsk_ff) - 2'(out_take);
   assign rrd      = (rcnt_ff != '0) && (occ < 2'd2);
   assign rrd_addr = rrp_ff;

   rva_ram #(.WIDTH(96), .DEPTH(RD)) u_rq (
      .clock(clock), .wr_en(b_wr), .wr_addr(rwp_ff), .wr_data({bx, by, bz}),
      .rd_addr(rrd_addr), .rd_data(rd_data)
   );

   always_comb begin
      rinfl_in = rinfl_ff + (take ? 1'b1 : 1'b0) - (b_wr ? 1'b1 : 1'b0);
      rcnt_in  = rcnt_ff + (b_wr ? 1'b1 : 1'b0) - (rrd ? 1'b1 : 1'b0);
   end

   // rsk marks a read in progress; data lands in the output or skid slot next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rcnt_ff   <= '0;
         rinfl_ff  <= '0;
         rwp_ff    <= '0;
         rrp_ff    <= '0;
         rvalid_ff <= 1'b0;
         rsk_ff    <= 1'b0;
         skv_ff    <= 1'b0;
      end else begin
         rcnt_ff  <= rcnt_in;
         rinfl_ff <= rinfl_in;
         rsk_ff   <= rrd;
         if (b_wr) begin
            rwp_ff <= rwp_ff + 1'b1;
         end
         if (rrd) begin
            rrp_ff <= rrp_ff + 1'b1;
         end
         if (out_take) begin
            if (skv_ff) begin
               skv_ff <= rsk_ff;
            end else begin
               rvalid_ff <= rsk_ff;
            end
         end else if (rsk_ff) begin
            if (rvalid_ff) begin
               skv_ff <= 1'b1;
            end else begin
               rvalid_ff <= 1'b1;
            end
         end
      end
   end

   logic [95:0] out_ff;
   always_ff @(posedge clock) begin
      if (out_take) begin
         if (skv_ff) begin
            out_ff <= sk_ff;
            if (rsk_ff) begin
               sk_ff <= rd_data;
            end
         end else if (rsk_ff) begin
            out_ff <= rd_data;
         end
      end else if (rsk_ff) begin
         if (rvalid_ff) begin
            sk_ff <= rd_data;
         end else begin
            out_ff <= rd_data;
         end
      end
   end

   assign empty          = !rvalid_ff;
   assign rsp_new_view_x = out_ff[95:64];
   assign rsp_new_view_y = out_ff[63:32];
   assign rsp_new_view_z = out_ff[31:0];

`ifndef SYNTHESIS
   a_rq_room: assert property (@(posedge clock) disable iff (reset)
      !(b_wr && (32'(rcnt_ff) >= RD)))
      else $error("result queue overflow");
   a_fq_room: assert property (@(posedge clock) disable iff (reset)
      !(f_valid && (32'(qcnt_ff) >= QD)))
      else $error("item queue overflow");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(out_ff)))
      else $error("waiting result changed");
`endif
endmodule
`default_nettype wire

@@ dv/tb_rotate_view_about_axis_top.sv @@
// tb_rotate_view_about_axis_top: self-checking bench for the view rotation block
// drives the push/full queue, predicts each rotated target or takes a given one, and checks popped items
// depends on rotate_view_about_axis_top
`default_nettype none
module tb_rotate_view_about_axis_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AXF = 14;
   localparam int ANF = 13;
   localparam int STEPS = 16;
   localparam longint LIMIT = 400000;

   typedef struct {
      logic signed [31:0] px, py, pz, vx, vy, vz;
      logic signed [15:0] ax, ay, az, ang;
   } view_item_t;

   typedef struct {
      logic signed [31:0] x, y, z;
   } target_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [31:0] req_view_x = '0, req_view_y = '0, req_view_z = '0;
   logic signed [15:0] req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic signed [15:0] req_turn_angle = '0;
   logic signed [31:0] rsp_new_view_x, rsp_new_view_y, rsp_new_view_z;

   target_t expected_targets[$];
   int errors = 0;
   bit stim_done = 0;
   longint cycles = 0;
   int pop_gap = 0;

   rotate_view_about_axis_top u_top (.*);

   always #10 clock = ~clock;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic target_t rotate_target(view_item_t it);
      longint p[3], d[3], dh[3], dl[3], m[3][3], a[3];
      longint ang, x, y, nx, c, s, t, hi, lo, hq, hr, rot, e;
      longint atn[16] = '{843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
                          16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                          262143, 131071, 65535, 32767};
      bit flip;
      target_t res;
      p[0] = it.px; p[1] = it.py; p[2] = it.pz;
      d[0] = longint'(it.vx) - p[0];
      d[1] = longint'(it.vy) - p[1];
      d[2] = longint'(it.vz) - p[2];
      for (int k = 0; k < 3; k++) begin
         dh[k] = floor_shift(d[k], 16);
         dl[k] = d[k] - dh[k] * 65536;
      end
      a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
      ang = longint'(it.ang) * (longint'(1) << (30 - ANF));
      ang = ang % 64'sd6746518852;
      if (ang > 64'sd3373259426) ang -= 64'sd6746518852;
      if (ang < -64'sd3373259426) ang += 64'sd6746518852;
      flip = 0;
      if (ang > 64'sd1686629713) begin
         ang -= 64'sd3373259426; flip = 1;
      end else if (ang < -64'sd1686629713) begin
         ang += 64'sd3373259426; flip = 1;
      end
      x = 652032874; y = 0;
      for (int i = 0; i < STEPS; i++) begin
         if (ang >= 0) begin
            nx = x - floor_shift(y, i); y = y + floor_shift(x, i); ang -= atn[i];
         end else begin
            nx = x + floor_shift(y, i); y = y - floor_shift(x, i); ang += atn[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
      t = (longint'(1) << 30) - c;
      for (int r = 0; r < 3; r++)
         for (int k = 0; k < 3; k++)
            m[r][k] = floor_shift(t * a[r] * a[k], 2 * AXF) + (r == k ? c : 0);
      m[0][1] -= floor_shift(a[2] * s, AXF);
      m[1][0] += floor_shift(a[2] * s, AXF);
      m[0][2] += floor_shift(a[1] * s, AXF);
      m[2][0] -= floor_shift(a[1] * s, AXF);
      m[1][2] -= floor_shift(a[0] * s, AXF);
      m[2][1] += floor_shift(a[0] * s, AXF);
      for (int r = 0; r < 3; r++) begin
         hi = 0;
         lo = longint'(1) << 29;
         for (int k = 0; k < 3; k++) begin
            e = clip(m[r][k], -(longint'(1) << 32), longint'(1) << 32);
            hi += e * dh[k];
            lo += e * dl[k];
         end
         hq = floor_shift(hi, 14);
         hr = hi - hq * (longint'(1) << 14);
         rot = hq + floor_shift(hr * 65536 + lo, 30);
         p[r] = clip(p[r] + rot, -64'sd2147483648, 64'sd2147483647);
      end
      res.x = p[0][31:0]; res.y = p[1][31:0]; res.z = p[2][31:0];
      return res;
   endfunction

   task automatic send_item(view_item_t it, bit typed, target_t want);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_pos_x <= it.px; req_pos_y <= it.py; req_pos_z <= it.pz;
      req_view_x <= it.vx; req_view_y <= it.vy; req_view_z <= it.vz;
      req_axis_x <= it.ax; req_axis_y <= it.ay; req_axis_z <= it.az;
      req_turn_angle <= it.ang;
      do @(posedge clock); while (full);
      expected_targets.push_back(typed ? want : rotate_target(it));
   endtask

   function automatic view_item_t rand_item(bit wild);
      view_item_t it;
      int mode;
      logic signed [15:0] axes[3];
      mode = $urandom_range(0, 3);
      it.px = $urandom; it.py = $urandom; it.pz = $urandom;
      if (mode == 0) begin
         it.vx = $urandom; it.vy = $urandom; it.vz = $urandom;
      end else begin
         it.px = $signed(it.px) >>> 8; it.py = $signed(it.py) >>> 8;
         it.pz = $signed(it.pz) >>> 8;
         it.vx = it.px + ($signed($urandom) >>> (mode * 6));
         it.vy = it.py + ($signed($urandom) >>> (mode * 6));
         it.vz = it.pz + ($signed($urandom) >>> (mode * 6));
      end
      if (wild) begin
         it.ax = $urandom; it.ay = $urandom; it.az = $urandom; it.ang = $urandom;
      end else begin
         axes[0] = 0; axes[1] = 0; axes[2] = 0;
         case ($urandom_range(0, 2))
            0: axes[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16384 : -16384;
            1: begin
               axes[0] = $urandom_range(0, 1) ? 9459 : -9459;
               axes[1] = $urandom_range(0, 1) ? 9459 : -9459;
               axes[2] = $urandom_range(0, 1) ? 9459 : -9459;
            end
            default: begin
               axes[0] = $urandom_range(0, 1) ? 11585 : -11585;
               axes[$urandom_range(1, 2)] = $urandom_range(0, 1) ? 11585 : -11585;
            end
         endcase
         it.ax = axes[0]; it.ay = axes[1]; it.az = axes[2];
         it.ang = $signed($urandom_range(0, 51472)) - 25736;
      end
      return it;
   endfunction

   initial begin
      view_item_t dir_rows[$];
      view_item_t it;
      target_t want;
      bit typed[$];
      target_t wants[$];
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // zero angle about the x axis
      it = '{32'sd65536, -32'sd65536, 32'sd0, 32'sd131072, 32'sd0, 32'sd65536,
             16'sd16384, 16'sd0, 16'sd0, 16'sd0};
      dir_rows.push_back(it); typed.push_back(0);
      want = '{32'sd131072, 32'sd0, 32'sd65536}; wants.push_back(want);
      // target equal to position stays put
      it = '{32'sd7, 32'sd9, -32'sd3, 32'sd7, 32'sd9, -32'sd3, 16'sd0, 16'sd16384, 16'sd0,
             16'sd12868};
      dir_rows.push_back(it); typed.push_back(1);
      want = '{32'sd7, 32'sd9, -32'sd3}; wants.push_back(want);
      // extremes of coordinates, axes and angles
      it = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             32'h80000000, 16'sd16384, 16'sd0, 16'sd0, 16'sd25736};
      dir_rows.push_back(it); typed.push_back(0); wants.push_back(want);
      it = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'h80000000, 32'h0,
             16'sd0, 16'sd0, -16'sd16384, -16'sd25736};
      dir_rows.push_back(it); typed.push_back(0); wants.push_back(want);
      it = '{32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 16'sd0, 16'sd0, 16'sd16384,
             16'sd12868};
      dir_rows.push_back(it); typed.push_back(0); wants.push_back(want);
      // angles beyond pi and raw bit patterns
      it = '{32'h0, 32'h0, 32'h0, 32'h00010000, 32'h00020000, 32'h0, 16'sd0, 16'sd0,
             16'sd16384, 16'h7fff};
      dir_rows.push_back(it); typed.push_back(0); wants.push_back(want);
      it = '{32'h0, 32'h0, 32'h0, 32'h00010000, 32'h00020000, 32'h0, 16'sd0, 16'sd0,
             16'sd16384, 16'h8000};
      dir_rows.push_back(it); typed.push_back(0); wants.push_back(want);
      it = '{32'h0, 32'h0, 32'h0, 32'h00010000, 32'h00020000, 32'h0, 16'sd0, 16'sd0,
             16'sd16384, 16'hffff};
      dir_rows.push_back(it); typed.push_back(0); wants.push_back(want);
      // axes far from unit length, entries saturate
      it = '{32'h1000, 32'h2000, 32'h3000, 32'h7fff0000, 32'h80000000, 32'h12345678,
             16'h7fff, 16'h8000, 16'h7fff, 16'sd6000};
      dir_rows.push_back(it); typed.push_back(0); wants.push_back(want);
      it = '{32'hffffffff, 32'h1, 32'h0, 32'h55555555, 32'haaaaaaaa, 32'hffff0000,
             16'h8000, 16'h8000, 16'h8000, 16'h8000};
      dir_rows.push_back(it); typed.push_back(0); wants.push_back(want);
      it = '{32'h0, 32'h0, 32'h0, 32'h00010000, 32'h00010000, 32'h00010000, 16'sd9459,
             16'sd9459, 16'sd9459, 16'sd17157};
      dir_rows.push_back(it); typed.push_back(0); wants.push_back(want);
      foreach (dir_rows[i]) send_item(dir_rows[i], typed[i], wants[i]);
      for (int n = 0; n < 550; n++) begin
         if (n == 250) begin
            push <= 1'b0;
            wait (expected_targets.size() == 0);
         end
         if (n >= 300 && n < 340) send_item(rand_item(1), 0, want);
         else send_item(rand_item($urandom_range(0, 9) == 0), 0, want);
      end
      push <= 1'b0;
      stim_done = 1;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_targets.size() == 0) begin
               $display("%0t unexpected item x=%0d y=%0d z=%0d", $time, rsp_new_view_x,
                        rsp_new_view_y, rsp_new_view_z);
               errors++;
            end else begin
               if (rsp_new_view_x !== expected_targets[0].x) begin
                  $display("%0t x expected %0d actual %0d", $time, expected_targets[0].x,
                           rsp_new_view_x);
                  errors++;
               end
               if (rsp_new_view_y !== expected_targets[0].y) begin
                  $display("%0t y expected %0d actual %0d", $time, expected_targets[0].y,
                           rsp_new_view_y);
                  errors++;
               end
               if (rsp_new_view_z !== expected_targets[0].z) begin
                  $display("%0t z expected %0d actual %0d", $time, expected_targets[0].z,
                           rsp_new_view_z);
                  errors++;
               end
               void'(expected_targets.pop_front());
            end
            pop_gap = ((cycles / 2000) % 3 == 1) ? 0 : $urandom_range(0, 17);
         end else if (pop_gap > 0) begin
            pop_gap--;
         end
         pop <= (pop_gap == 0);
      end
   end

   initial begin
      wait (stim_done && expected_targets.size() == 0);
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_targets.size() == 0) $display("PASS rotate_view_about_axis_top");
      else $display("FAIL rotate_view_about_axis_top");
      $finish;
   end

   initial begin
      wait (cycles >= LIMIT);
      $display("FAIL rotate_view_about_axis_top");
      $finish;
   end
endmodule
`default_nettype wire
